/* hdl/text_console_writer_top_macros.svh */
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/txc_pkg.sv */
`default_nettype none

package txc_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        OP_PUT       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    // attribute in the high byte, character in the low byte
    function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                    input logic [CHAR_W-1:0] ch);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

/* hdl/txc_ram.sv */
`default_nettype none

module txc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/text_console_writer_top.sv */
// text console writer: a rows-by-columns buffer of 16-bit cells and a cursor
//
// input channel (in_valid / in_stall): one beat carries opcode, char_code,
// read_row and read_column; it is taken when in_valid is high and in_stall low.
// output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order: cursor position after the operation, scroll flag, cell value.
// cfg_write / cfg_data set the text attribute; write it only while idle.
//
// put, newline and backspace: the accepted beat passes through S_EMIT into
// the result register. read: S_READ takes the registered read of the cell
// ram, then S_EMIT. put that scrolls: the screen is a ring of rows, so a
// scroll moves the top-row pointer and blanks one row, a cell per cycle.
// clear: all ROWS*COLUMNS cells are blanked, one ram write per cycle.
// one beat is worked on at a time; a new beat can be taken while the previous
// result still waits in the output register, and that one is held while
// out_stall is high.
// after reset the ram is swept to blanks (space, attribute 0x07), all
// ROWS*COLUMNS cells, with in_stall high; cfg writes are taken meanwhile.
`default_nettype none

`include "text_console_writer_top_macros.svh"

module text_console_writer_top import txc_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_write,
    input  wire logic [ATTR_W-1:0] cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [ROW_W-1:0]  read_row,
    input  wire logic [COL_W-1:0]  read_column,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [COL_W-1:0]       cursor_column,
    output logic [ROW_W-1:0]       cursor_row,
    output logic                   scrolled,
    output logic [CELL_W-1:0]      cell_value
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_END_A = ADDR_W'(COLUMNS - 1);
    localparam logic [COL_W:0]    COLS_X    = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    // physical ram row that holds logical row 0
    logic [ROW_W-1:0]    top_reg;
    logic [ADDR_W-1:0]   sweep_addr_reg;
    logic [ADDR_W-1:0]   sweep_last_reg;
    logic [CELL_W-1:0]   fill_data_reg;
    logic                emit_after_fill_reg;
    logic                res_scrolled_reg;
    logic [CELL_W-1:0]   res_cell_reg;
    logic                out_valid_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                out_scrolled_reg;
    logic [CELL_W-1:0]   out_cell_reg;

    logic                accept;
    op_t                 op;
    logic                is_newline;
    logic [COL_W:0]      put_col;
    logic [ROW_W:0]      put_row;
    logic                put_scroll;
    logic [COL_W-1:0]    bs_col;
    logic [ROW_W-1:0]    bs_row;
    logic                read_in_range;
    logic [ROW_W-1:0]    top_inc;
    logic [ADDR_W-1:0]   top_base;
    logic [CELL_W-1:0]   blank;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;

    // logical row to physical ram row through the ring offset
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, r} + {1'b0, top};
        if (sum >= ROWS_X)
        begin
            sum = sum - ROWS_X;
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(prow) * COLS_A) + ADDR_W'(c);
    endfunction

    assign accept     = in_valid && !in_stall;
    assign op         = op_t'(opcode);
    assign is_newline = (char_code == NEWLINE_CHAR);
    assign blank      = make_cell(attr_reg, BLANK_CHAR);
    assign top_inc    = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
    assign top_base   = ADDR_W'(ADDR_W'(top_reg) * COLS_A);

    assign read_in_range = ({1'b0, read_row} < ROWS_X) && ({1'b0, read_column} < COLS_X);

    // cursor after a put: advance or newline, wrap the column, then scroll
    always_comb
    begin
        if (is_newline)
        begin
            put_col = '0;
            put_row = {1'b0, row_reg} + 1'b1;
        end
        else
        begin
            put_col = {1'b0, col_reg} + 1'b1;
            put_row = {1'b0, row_reg};
        end
        if (put_col >= COLS_X)
        begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        put_scroll = (put_row >= ROWS_X);
        if (put_scroll)
        begin
            put_row = {1'b0, LAST_ROW};
        end
    end

    // cursor after a backspace; at home it stays put
    always_comb
    begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - 1'b1;
        end
        else if (row_reg != '0)
        begin
            bs_row = row_reg - 1'b1;
            bs_col = LAST_COL;
        end
    end

    // ram port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_addr_reg;
        mem_wdata = fill_data_reg;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(phys_row(read_row, top_reg), read_column);
        case (state_reg)
            S_FILL:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_PUT:
                        begin
                            mem_we    = !is_newline;
                            mem_waddr = cell_addr(phys_row(row_reg, top_reg), col_reg);
                            mem_wdata = make_cell(attr_reg, char_code);
                        end
                        OP_BACKSPACE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(phys_row(bs_row, top_reg), bs_col);
                            mem_wdata = blank;
                        end
                        OP_READ:
                        begin
                            mem_re = read_in_range;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // power-up sweep fills the whole ram with the reset blank
            state_reg           <= S_FILL;
            attr_reg            <= RESET_ATTR;
            col_reg             <= '0;
            row_reg             <= '0;
            top_reg             <= '0;
            sweep_addr_reg      <= '0;
            sweep_last_reg      <= LAST_A;
            fill_data_reg       <= make_cell(RESET_ATTR, BLANK_CHAR);
            emit_after_fill_reg <= 1'b0;
            res_scrolled_reg    <= 1'b0;
            res_cell_reg        <= '0;
            out_valid_reg       <= 1'b0;
            out_col_reg         <= '0;
            out_row_reg         <= '0;
            out_scrolled_reg    <= 1'b0;
            out_cell_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end

            // a waiting result leaves unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_FILL:
                begin
                    if (sweep_addr_reg == sweep_last_reg)
                    begin
                        state_reg <= emit_after_fill_reg ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_scrolled_reg <= (op == OP_PUT) && put_scroll;
                        res_cell_reg     <= '0;
                        case (op)
                            OP_PUT:
                            begin
                                col_reg          <= put_col[COL_W-1:0];
                                row_reg          <= put_row[ROW_W-1:0];
                                if (put_scroll)
                                begin
                                    // old top row becomes the new bottom row
                                    top_reg             <= top_inc;
                                    sweep_addr_reg      <= top_base;
                                    sweep_last_reg      <= top_base + ROW_END_A;
                                    fill_data_reg       <= blank;
                                    emit_after_fill_reg <= 1'b1;
                                    state_reg           <= S_FILL;
                                end
                                else
                                begin
                                    state_reg <= S_EMIT;
                                end
                            end
                            OP_BACKSPACE:
                            begin
                                col_reg   <= bs_col;
                                row_reg   <= bs_row;
                                state_reg <= S_EMIT;
                            end
                            OP_CLEAR:
                            begin
                                col_reg             <= '0;
                                row_reg             <= '0;
                                top_reg             <= '0;
                                sweep_addr_reg      <= '0;
                                sweep_last_reg      <= LAST_A;
                                fill_data_reg       <= blank;
                                emit_after_fill_reg <= 1'b1;
                                state_reg           <= S_FILL;
                            end
                            OP_READ:
                            begin
                                state_reg <= read_in_range ? S_READ : S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    res_cell_reg <= mem_rdata;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_col_reg      <= col_reg;
                        out_row_reg      <= row_reg;
                        out_scrolled_reg <= res_scrolled_reg;
                        out_cell_reg     <= res_cell_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    txc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT),
        .ADDR_W(ADDR_W)
    ) u_cells (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign scrolled      = out_scrolled_reg;
    assign cell_value    = out_cell_reg;

    `TCW_ASSERT_NOW(a_cursor_in_range, 1'b1,
        ({1'b0, row_reg} < ROWS_X) && ({1'b0, col_reg} < COLS_X) && ({1'b0, top_reg} < ROWS_X),
        "cursor or ring offset out of range")
    `TCW_ASSERT_NOW(a_no_ram_collision, mem_we, !mem_re,
        "cell ram written and read in the same cycle")
    `TCW_ASSERT_NOW(a_sweep_bounded, state_reg == S_FILL, sweep_addr_reg <= sweep_last_reg,
        "fill sweep ran past its last cell")
    `TCW_ASSERT_NOW(a_scroll_on_last_row, out_valid && scrolled,
        (cursor_row == LAST_ROW) && (cell_value == '0),
        "scrolled beat without cursor on the last row")
    `TCW_ASSERT_NEXT(a_read_then_emit, state_reg == S_READ, state_reg == S_EMIT,
        "read result not passed on")

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

// checks the text console writer against a shadow screen and cursor kept here
module testbench;
    import txc_pkg::*;

    localparam int COLUMNS = COLUMNS_DEFAULT;
    localparam int ROWS    = ROWS_DEFAULT;
    localparam int CELLS   = ROWS * COLUMNS;

    // cycles with no beat on either channel before the run is called hung;
    // the longest quiet spells are the sweep after reset and a clear, each over
    // all 2000 cells, plus the long receiver hold-off
    localparam int IDLE_LIMIT   = 25000;
    localparam int HOLD_AT      = 300;   // result count at which the receiver holds off
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 170;
    localparam int PHASE_COUNT  = 5;
    localparam int TAIL_CYCLES  = 100;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
        logic [CELL_W-1:0] cell_data;
    } console_result_t;

    // one directed beat; fixed rows carry a hand-written result
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rd_row;
        logic [COL_W-1:0]  rd_col;
        bit                fixed;
        console_result_t   want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [ATTR_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [ROW_W-1:0]  read_row = '0;
    logic [COL_W-1:0]  read_column = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;

    // shadow of the block state
    logic [CELL_W-1:0] screen_shadow [CELLS];
    int                col_shadow;
    int                row_shadow;
    logic [ATTR_W-1:0] attr_shadow;

    console_result_t   pending_results [$];
    stim_row_t         directed_rows [$];
    int                mismatch_count = 0;
    int                beats_sent = 0;
    int                results_seen = 0;

    always #5 clk = ~clk;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_column   (read_column),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .scrolled      (scrolled),
        .cell_value    (cell_value)
    );

    // applies one operation to the shadow screen and returns the result beat
    function automatic console_result_t apply_console_op(input op_t op,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [ROW_W-1:0] rd_row,
                                                         input logic [COL_W-1:0] rd_col);
        console_result_t   res;
        logic [CELL_W-1:0] blank;
        int                i;
        res   = '0;
        blank = {attr_shadow, BLANK_CHAR};
        case (op)
            OP_PUT:
            begin
                if (ch == NEWLINE_CHAR)
                begin
                    col_shadow = 0;
                    row_shadow++;
                end
                else
                begin
                    screen_shadow[row_shadow * COLUMNS + col_shadow] = {attr_shadow, ch};
                    col_shadow++;
                end
                // past the last column: wrap to the next row
                if (col_shadow >= COLUMNS)
                begin
                    col_shadow = 0;
                    row_shadow++;
                end
                // off the bottom: every row moves up, last row blanked
                if (row_shadow >= ROWS)
                begin
                    for (i = COLUMNS; i < CELLS; i++)
                        screen_shadow[i - COLUMNS] = screen_shadow[i];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_shadow[i] = blank;
                    row_shadow   = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            OP_BACKSPACE:
            begin
                // at home the cursor stays put and the home cell is blanked
                if (col_shadow > 0)
                    col_shadow--;
                else if (row_shadow > 0)
                begin
                    row_shadow--;
                    col_shadow = COLUMNS - 1;
                end
                screen_shadow[row_shadow * COLUMNS + col_shadow] = blank;
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_shadow[i] = blank;
                col_shadow = 0;
                row_shadow = 0;
            end
            default:
            begin
                // out-of-range reads give zero
                if (rd_row < ROWS && rd_col < COLUMNS)
                    res.cell_data = screen_shadow[rd_row * COLUMNS + rd_col];
            end
        endcase
        res.column = COL_W'(col_shadow);
        res.row    = ROW_W'(row_shadow);
        return res;
    endfunction

    task automatic add_row(input op_t op, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rd_row, input logic [COL_W-1:0] rd_col,
                           input bit fixed, input int col, input int row,
                           input logic [CELL_W-1:0] cell_word);
        stim_row_t r;
        r.op          = op;
        r.ch          = ch;
        r.rd_row      = rd_row;
        r.rd_col      = rd_col;
        r.fixed       = fixed;
        r.want.column = COL_W'(col);
        r.want.row    = ROW_W'(row);
        r.want.scrolled = 1'b0;
        r.want.cell_data = cell_word;
        directed_rows.push_back(r);
    endtask

    // offers one input beat after a random gap and records what it should give;
    // called and returning at a falling edge
    task automatic send_beat(input op_t op, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rd_row, input logic [COL_W-1:0] rd_col,
                             input bit fixed, input console_result_t want);
        int              gap;
        console_result_t predicted;
        // every fifth run of 60 beats goes back to back
        gap = ((beats_sent / 60) % 5 == 4) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        char_code   <= ch;
        read_row    <= rd_row;
        read_column <= rd_col;
        // beat is taken at the first rising edge with stall low
        do @(posedge clk); while (in_stall);
        predicted = apply_console_op(op, ch, rd_row, rd_col);
        pending_results.push_back(fixed ? want : predicted);
        beats_sent++;
        @(negedge clk);
    endtask

    // random beat: mostly text with plenty of newlines so that rows wrap and
    // the screen scrolls, some reads and backspaces, rare clears
    task automatic random_beat();
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rd_row;
        logic [COL_W-1:0]  rd_col;
        int                pick;
        pick   = $urandom_range(0, 199);
        ch     = CHAR_W'($urandom_range(0, 255));
        rd_row = ROW_W'($urandom_range(0, 31));
        rd_col = COL_W'($urandom_range(0, 127));
        if (pick == 0)
            op = OP_CLEAR;
        else if (pick <= 20)
            op = OP_BACKSPACE;
        else if (pick <= 70)
        begin
            op = OP_READ;
            // most reads land on the screen, the rest anywhere in the fields
            if ($urandom_range(0, 7) != 0)
            begin
                rd_row = ROW_W'($urandom_range(0, ROWS - 1));
                rd_col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        end
        else
        begin
            op = OP_PUT;
            if ($urandom_range(0, 99) < 40)
                ch = NEWLINE_CHAR;
        end
        send_beat(op, ch, rd_row, rd_col, 1'b0, '0);
    endtask

    // sender stops and waits until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] attr);
        cfg_write <= 1'b1;
        cfg_data  <= attr;
        @(negedge clk);
        cfg_write   <= 1'b0;
        attr_shadow = attr;
    endtask

    // main sequence: reset, directed rows, then random phases under
    // different attributes
    initial
    begin : stimulus
        logic [ATTR_W-1:0] phase_attr [PHASE_COUNT];
        int                p;
        int                i;
        attr_shadow = RESET_ATTR;
        for (i = 0; i < CELLS; i++)
            screen_shadow[i] = {RESET_ATTR, BLANK_CHAR};
        col_shadow = 0;
        row_shadow = 0;

        // extremes first, then a random setting, a mixed colour pair and another random one
        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = ATTR_W'($urandom_range(0, 255));
        phase_attr[3] = 8'h5A;
        phase_attr[4] = ATTR_W'($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows at the reset attribute
        // reads straight after reset: blank cells, corners and out of range
        add_row(OP_READ,      8'hFF, 5'd0,  7'd0,   1'b1, 0,  0, 16'h0720);
        add_row(OP_READ,      8'h00, 5'd24, 7'd79,  1'b1, 0,  0, 16'h0720);
        add_row(OP_READ,      8'h00, 5'd25, 7'd0,   1'b1, 0,  0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd0,  7'd80,  1'b1, 0,  0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd31, 7'd127, 1'b1, 0,  0, 16'h0000);
        // backspace at home
        add_row(OP_BACKSPACE, 8'hFF, 5'd31, 7'd127, 1'b1, 0,  0, 16'h0000);
        // character extremes, fields not used by put set high
        add_row(OP_PUT,       8'hFF, 5'd31, 7'd127, 1'b1, 1,  0, 16'h0000);
        add_row(OP_PUT,       8'h00, 5'd0,  7'd0,   1'b1, 2,  0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd0,  7'd0,   1'b1, 2,  0, 16'h07FF);
        add_row(OP_READ,      8'hFF, 5'd0,  7'd1,   1'b1, 2,  0, 16'h0700);
        add_row(OP_PUT,       NEWLINE_CHAR, 5'd0, 7'd0, 1'b1, 0, 1, 16'h0000);
        // backspace from column 0 crosses to the end of the row above
        add_row(OP_BACKSPACE, 8'h00, 5'd0,  7'd0,   1'b1, 79, 0, 16'h0000);
        // put in the last column wraps
        add_row(OP_PUT,       8'h5A, 5'd0,  7'd0,   1'b1, 0,  1, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd0,  7'd79,  1'b1, 0,  1, 16'h075A);
        // newline code on a backspace is ignored
        add_row(OP_BACKSPACE, NEWLINE_CHAR, 5'd0, 7'd0, 1'b1, 79, 0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd0,  7'd79,  1'b1, 79, 0, 16'h0720);
        add_row(OP_CLEAR,     NEWLINE_CHAR, 5'd24, 7'd79, 1'b1, 0, 0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd24, 7'd79,  1'b1, 0,  0, 16'h0720);
        // a few more checked against the shadow only
        add_row(OP_PUT,       8'h80, 5'd0,  7'd0,   1'b0, 0,  0, 16'h0000);
        add_row(OP_PUT,       8'h7F, 5'd0,  7'd0,   1'b0, 0,  0, 16'h0000);
        add_row(OP_READ,      8'h00, 5'd0,  7'd1,   1'b0, 0,  0, 16'h0000);
        add_row(OP_BACKSPACE, 8'h00, 5'd0,  7'd0,   1'b0, 0,  0, 16'h0000);

        @(negedge clk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].rd_row,
                      directed_rows[i].rd_col, directed_rows[i].fixed, directed_rows[i].want);

        // attribute only changes once the block has gone quiet
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            write_attribute(phase_attr[p]);
            repeat (PHASE_ITEMS) random_beat();
        end

        drain();
        // any stray result beat in the tail is caught by the receiver
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall per beat, runs of no stall, one long hold-off
    // while the sender keeps offering so that the block backs up
    initial
    begin : receiver
        int              stall_len;
        console_result_t want;
        wait (rst_n);
        forever
        begin
            if (results_seen == HOLD_AT)
                stall_len = HOLD_CYCLES;
            else if ((results_seen / 45) % 4 == 3)
                stall_len = 0;
            else
                stall_len = $urandom_range(0, 9);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: column %0d row %0d cell %h",
                       cursor_column, cursor_row, cell_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cursor_column !== want.column)
                begin
                    $error("cursor_column: expected %0d, got %0d", want.column, cursor_column);
                    mismatch_count++;
                end
                if (cursor_row !== want.row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
                    mismatch_count++;
                end
                if (scrolled !== want.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, scrolled);
                    mismatch_count++;
                end
                if (cell_value !== want.cell_data)
                begin
                    $error("cell_value: expected %h, got %h", want.cell_data, cell_value);
                    mismatch_count++;
                end
            end
            results_seen++;
            @(negedge clk);
        end
    end

    // watchdog: too long without a beat on either channel ends the run
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/txc_pkg.sv
hdl/txc_ram.sv
hdl/text_console_writer_top.sv
test/testbench.sv
